// ----- src/vwit_pkg.sv -----
// ---------------------------------------------------------------------------
// vwit_pkg
// Shared constants, types and helpers for the vertex weld index table.
// ---------------------------------------------------------------------------
`default_nettype none

package vwit_pkg;

    // table geometry
    localparam int MAX_VERTICES = 256;
    localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // field widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int TOL_W   = 31;
    localparam int VIDX_W  = 8;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture item, restart scan
        logic scan;    // run the table scan
        logic decide;  // resolve hit, append or overflow
        logic emit;    // move result into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic hit;       // matching entry at the end of the compare pipe
        logic drained;   // all entries issued and the pipe is empty
        logic out_free;  // output register can take a result
    } t_status;

    // table count or entry number to the 8-bit result index
    function automatic logic [VIDX_W-1:0] to_vidx(input logic [CNT_W-1:0] v);
        logic [CNT_W+VIDX_W-1:0] t;
        t = {{VIDX_W{1'b0}}, v};
        return t[VIDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/vwit_if.sv -----
// ---------------------------------------------------------------------------
// vwit_if
// Valid/ready channels for vertex items and index results.
// ---------------------------------------------------------------------------
`default_nettype none

interface vwit_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vwit_pkg::COORD_W-1:0]  x_coord;
    logic signed [vwit_pkg::COORD_W-1:0]  y_coord;
    logic signed [vwit_pkg::COORD_W-1:0]  z_coord;
    logic                                 first;

    modport source (output valid, x_coord, y_coord, z_coord, first, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, first, output ready);
endinterface

interface vwit_out_if;
    logic                          valid;
    logic                          ready;
    logic [vwit_pkg::VIDX_W-1:0]   vertex_index;
    logic                          added;
    logic                          overflow;

    modport source (output valid, vertex_index, added, overflow, input ready);
    modport sink   (input valid, vertex_index, added, overflow, output ready);
endinterface

`default_nettype wire

// ----- src/vwit_ctrl.sv -----
// ---------------------------------------------------------------------------
// vwit_ctrl
// Sequencer for one item: capture, scan the table, resolve, hand off result.
// ---------------------------------------------------------------------------
`default_nettype none

module vwit_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire vwit_pkg::t_status i_status,
    output vwit_pkg::t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_HOLD   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.hit || i_status.drained) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_HOLD;
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- src/vwit_dp.sv -----
// ---------------------------------------------------------------------------
// vwit_dp
// Vertex table memory, pipelined compare scan, append logic and the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

module vwit_dp (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire vwit_pkg::t_cmd                       i_cmd,
    output vwit_pkg::t_status                         o_status,
    input  wire logic [vwit_pkg::TOL_W-1:0]           i_tol,
    input  wire logic signed [vwit_pkg::COORD_W-1:0]  i_x,
    input  wire logic signed [vwit_pkg::COORD_W-1:0]  i_y,
    input  wire logic signed [vwit_pkg::COORD_W-1:0]  i_z,
    input  wire logic                                 i_first,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [vwit_pkg::VIDX_W-1:0]               o_vertex_index,
    output logic                                      o_added,
    output logic                                      o_overflow
);

    localparam int CW = vwit_pkg::COORD_W;
    localparam int DW = vwit_pkg::DIFF_W;
    localparam int AW = vwit_pkg::ADDR_W;
    localparam int NW = vwit_pkg::CNT_W;

    // table memory, one entry holds x, y and z
    logic [3*CW-1:0] mem [vwit_pkg::MAX_VERTICES];

    // captured item
    logic [CW-1:0] r_x, r_y, r_z;

    // table fill and scan address
    logic [NW-1:0] r_count;
    logic [NW-1:0] r_addr;

    // compare pipeline
    logic            r_s1_v;
    logic [AW-1:0]   r_s1_idx;
    logic [3*CW-1:0] r_rd_data;
    logic            r_s2_v;
    logic [AW-1:0]   r_s2_idx;
    logic [DW-1:0]   r_dx, r_dy, r_dz;

    // pending result
    logic                        r_found;
    logic [vwit_pkg::VIDX_W-1:0] r_res_idx;
    logic                        r_res_added;
    logic                        r_res_ovf;

    // output register
    logic                        r_out_valid;
    logic [vwit_pkg::VIDX_W-1:0] r_out_idx;
    logic                        r_out_added;
    logic                        r_out_ovf;

    logic          issue;
    logic          full;
    logic          hit;
    logic [DW-1:0] tol_p;
    logic [DW-1:0] tol_n;
    logic [DW-1:0] n_dx, n_dy, n_dz;
    logic          mx, my, mz;

    // scan issue and table state
    assign issue = i_cmd.scan && (r_addr < r_count);
    assign full  = (r_count >= NW'(vwit_pkg::MAX_VERTICES));

    // signed differences at full precision, never wrap
    assign n_dx = DW'($signed({r_rd_data[3*CW-1], r_rd_data[3*CW-1:2*CW]})
                    - $signed({r_x[CW-1], r_x}));
    assign n_dy = DW'($signed({r_rd_data[2*CW-1], r_rd_data[2*CW-1:CW]})
                    - $signed({r_y[CW-1], r_y}));
    assign n_dz = DW'($signed({r_rd_data[CW-1], r_rd_data[CW-1:0]})
                    - $signed({r_z[CW-1], r_z}));

    // window test: -tol < d < tol
    assign tol_p = {{(DW-vwit_pkg::TOL_W){1'b0}}, i_tol};
    assign tol_n = -tol_p;
    assign mx = ($signed(r_dx) < $signed(tol_p)) && ($signed(r_dx) > $signed(tol_n));
    assign my = ($signed(r_dy) < $signed(tol_p)) && ($signed(r_dy) > $signed(tol_n));
    assign mz = ($signed(r_dz) < $signed(tol_p)) && ($signed(r_dz) > $signed(tol_n));
    assign hit = i_cmd.scan && r_s2_v && mx && my && mz;

    // status back to the controller
    assign o_status.hit      = hit;
    assign o_status.drained  = (r_addr >= r_count) && !r_s1_v && !r_s2_v;
    assign o_status.out_free = !r_out_valid || i_ready;

    // memory write on append
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && !r_found && !full) begin
            mem[r_count[AW-1:0]] <= {r_x, r_y, r_z};
        end
    end

    // memory read, registered
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= mem[r_addr[AW-1:0]];
        end
    end

    // item capture and difference stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end
        r_s1_idx <= r_addr[AW-1:0];
        r_s2_idx <= r_s1_idx;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_dz     <= n_dz;
    end

    // scan control, fill count and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_addr  <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_addr  <= '0;
                r_s1_v  <= 1'b0;
                r_s2_v  <= 1'b0;
                r_found <= 1'b0;
                if (i_first) begin
                    r_count <= '0;
                end
            end else if (i_cmd.scan) begin
                r_s1_v <= issue;
                r_s2_v <= r_s1_v;
                if (issue) begin
                    r_addr <= r_addr + NW'(1);
                end
                if (hit) begin
                    r_found <= 1'b1;
                end
            end else if (i_cmd.decide && !r_found && !full) begin
                r_count <= r_count + NW'(1);
            end
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_res_idx   <= vwit_pkg::to_vidx({1'b0, r_s2_idx});
            r_res_added <= 1'b0;
            r_res_ovf   <= 1'b0;
        end else if (i_cmd.decide && !r_found) begin
            if (full) begin
                r_res_idx   <= '0;
                r_res_added <= 1'b0;
                r_res_ovf   <= 1'b1;
            end else begin
                r_res_idx   <= vwit_pkg::to_vidx(r_count);
                r_res_added <= 1'b1;
                r_res_ovf   <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_idx   <= r_res_idx;
            r_out_added <= r_res_added;
            r_out_ovf   <= r_res_ovf;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_vertex_index = r_out_idx;
    assign o_added        = r_out_added;
    assign o_overflow     = r_out_ovf;

endmodule

`default_nettype wire

// ----- src/vertex_weld_index_table_top.sv -----
// ---------------------------------------------------------------------------
// vertex_weld_index_table_top
// Welds vertices within a tolerance into a table of unique entries.
//
// Usage:
//   i_vtx carries one vertex per item (signed Q16.16 x, y, z and a first
//   flag that empties the table). o_res returns one result per item: the
//   entry index, an added flag and an overflow flag.
//   The tolerance register sits at byte address 0 of the APB-style port;
//   coordinates match when each absolute difference is below it.
// Scan:
//   an item is compared against the table entry by entry until a match,
//   or through all entries on a miss. The single memory read port,
//   one entry per cycle into a two-stage compare pipe, sets this. One
//   item is in flight at a time and the next is accepted in the cycle
//   after the result is loaded into the output register.
// Reset:
//   the table is empty and the tolerance is 1 (exact match).
// Stall:
//   a result waits in the output register while o_res is stalled; the
//   next item is accepted meanwhile and holds in the last step until the
//   output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module vertex_weld_index_table_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    vwit_in_if.sink                              i_vtx,
    vwit_out_if.source                           o_res,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [vwit_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [vwit_pkg::PDATA_W-1:0]    pwdata,
    output logic [vwit_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    logic [vwit_pkg::TOL_W-1:0] r_tol;
    vwit_pkg::t_cmd             cmd;
    vwit_pkg::t_status          status;
    logic                       in_ready;
    logic                       wr_en;

    // configuration register
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= vwit_pkg::TOL_RESET;
        end else if (wr_en && (paddr[2] == vwit_pkg::REG_TOLERANCE)) begin
            r_tol <= pwdata[vwit_pkg::TOL_W-1:0];
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == vwit_pkg::REG_TOLERANCE) begin
            prdata = {{(vwit_pkg::PDATA_W-vwit_pkg::TOL_W){1'b0}}, r_tol};
        end
    end

    assign i_vtx.ready = in_ready;

    // controller
    vwit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vtx.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    vwit_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_tol          (r_tol),
        .i_x            (i_vtx.x_coord),
        .i_y            (i_vtx.y_coord),
        .i_z            (i_vtx.z_coord),
        .i_first        (i_vtx.first),
        .o_valid        (o_res.valid),
        .i_ready        (o_res.ready),
        .o_vertex_index (o_res.vertex_index),
        .o_added        (o_res.added),
        .o_overflow     (o_res.overflow)
    );

endmodule

`default_nettype wire
